@@ rtl/crre_pkg.sv @@
// ----------------------------------------------------------------------------
// crre_pkg
// Shared types and constants of the CAN request/reply engine: command,
// result and error codes, the classified item and the result record.
// ----------------------------------------------------------------------------
package crre_pkg;

  // Reply matching and echo rules
  localparam logic [28:0] EXT_MATCH_BIT    = 29'h0004_0000;
  localparam logic [28:0] STD_MATCH_BIT    = 29'h0000_0001;
  localparam logic [24:0] ECHO_FREE_PREFIX = 25'h000_0040;

  // Length limits
  localparam logic [3:0] MAX_DLC       = 4'd8;
  localparam logic [6:0] MAX_REPLY_LEN = 7'd64;
  localparam logic [7:0] ERR_COUNT_MAX = 8'hFF;

  // Register reset values
  localparam logic [7:0] COMM_LIMIT_RST = 8'd3;
  localparam logic [3:0] TRIES_RST      = 4'd3;

  // Register indexes (taken from paddr[2])
  localparam logic REG_COMM_ERROR_LIMIT = 1'b0;
  localparam logic REG_TRIES_PER_FRAME  = 1'b1;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_RX      = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_BUS_ERR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_TX   = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_COMM_LIMIT = 3'd1,
    ERR_NO_REPLY   = 3'd2,
    ERR_ECHO       = 3'd3,
    ERR_LENGTH     = 3'd4,
    ERR_BUS        = 3'd5
  } err_t;

  // Item after classification in the front end
  typedef struct packed {
    cmd_t        cmd;
    logic [28:0] id;
    logic        ext;
    logic [3:0]  len;        // raw data length code (request)
    logic [63:0] bytes;
    logic [6:0]  rlen;       // expected total reply length
    logic [3:0]  dlc;        // data length code capped at eight
    logic [3:0]  frames;     // reply frames expected for a start
    logic        echo_free;  // reply id prefix waives the echo check
    logic [63:0] pack_lo;    // bytes 1..dlc-1 moved down one byte
    logic [7:0]  pack_hi;    // byte 1 when dlc is two or more
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [28:0] tx_id;
    logic        tx_ext;
    logic [3:0]  tx_len;
    logic [63:0] tx_bytes;
    logic [63:0] reply;
    err_t        code;
    logic [7:0]  count;
    logic        last;
  } res_t;

endpackage

@@ rtl/crre_front.sv @@
// ----------------------------------------------------------------------------
// crre_front
// Input side: classifies each accepted item (caps, frame count, echo waiver,
// byte packing) and holds it in a short queue for the back end.
// ----------------------------------------------------------------------------
module crre_front import crre_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [28:0] in_frame_id,
  input  logic        in_frame_extended,
  input  logic [3:0]  in_frame_len,
  input  logic [63:0] in_frame_bytes,
  input  logic [6:0]  in_reply_length,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             cls;
  logic [6:0]        capped;
  logic [6:0]        frames_sum;
  item_t             mem [DEPTH];
  logic [PTR_W-1:0]  wp_r;
  logic [PTR_W-1:0]  rp_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PTR_W-1:0]  wp_inc;
  logic [PTR_W-1:0]  rp_inc;
  logic              push;

  // Classify the incoming item
  always_comb begin
    cls           = '0;
    cls.cmd       = cmd_t'(in_cmd);
    cls.id        = in_frame_id;
    cls.ext       = in_frame_extended;
    cls.len       = in_frame_len;
    cls.bytes     = in_frame_bytes;
    cls.rlen      = in_reply_length;
    cls.dlc       = (in_frame_len > MAX_DLC) ? MAX_DLC : in_frame_len;
    capped        = (in_reply_length > MAX_REPLY_LEN) ? MAX_REPLY_LEN : in_reply_length;
    frames_sum    = capped + 7'd7;
    cls.frames    = frames_sum[6:3];
    cls.echo_free = (in_frame_id[28:4] == ECHO_FREE_PREFIX);
    for (int k = 0; k < 7; k++) begin
      if (4'(k + 2) <= cls.dlc) begin
        cls.pack_lo[8*k +: 8] = in_frame_bytes[8*(k+1) +: 8];
      end
    end
    cls.pack_hi = (cls.dlc >= 4'd2) ? in_frame_bytes[15:8] : 8'h00;
  end

  // Queue control
  assign in_ready = (cnt_r != CNT_W'(DEPTH));
  assign push     = in_valid && in_ready;
  assign wp_inc   = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rp_inc   = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_inc;
      end
      if (q_pop) begin
        rp_r <= rp_inc;
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(q_pop);
    end
  end

  // Store the classified item
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= cls;
    end
  end

endmodule

@@ rtl/crre_back.sv @@
// ----------------------------------------------------------------------------
// crre_back
// Transaction side: keeps the request state, carries out one queued item per
// cycle while the result queue has room for two, and queues up to two results.
// ----------------------------------------------------------------------------
module crre_back import crre_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  limit_cfg,
  input  logic [3:0]  tries_cfg,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_res
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic        busy_r,          busy_nxt;
  logic [28:0] req_id_r,        req_id_nxt;
  logic        req_ext_r,       req_ext_nxt;
  logic [3:0]  req_len_r,       req_len_nxt;
  logic [63:0] req_bytes_r,     req_bytes_nxt;
  logic [6:0]  want_len_r,      want_len_nxt;
  logic [3:0]  frames_needed_r, frames_needed_nxt;
  logic [3:0]  frame_idx_r,     frame_idx_nxt;
  logic [3:0]  tries_left_r,    tries_left_nxt;
  logic [6:0]  got_len_r,       got_len_nxt;
  logic [63:0] accum_r,         accum_nxt;
  logic [7:0]  comm_err_r,      comm_err_nxt;

  res_t             oq_mem [DEPTH];
  logic [PTR_W-1:0] oq_wp_r;
  logic [PTR_W-1:0] oq_rp_r;
  logic [CNT_W-1:0] oq_cnt_r;
  logic [PTR_W-1:0] wp_inc1;
  logic [PTR_W-1:0] wp_inc2;
  logic [PTR_W-1:0] rp_inc;
  logic             oq_pop;

  item_t       it;
  logic        take;
  res_t        r0;
  res_t        r1;
  logic [1:0]  nres;
  logic [28:0] expect_id;
  logic [3:0]  tries_dec;
  logic [3:0]  reload;
  logic [6:0]  got_sum;
  logic [3:0]  idx_inc;
  logic [63:0] accum_new;
  logic [7:0]  comm_inc;

  function automatic res_t mk_res(kind_t kind, err_t code, logic [63:0] data,
                                  logic [7:0] cnt);
    res_t r;
    r       = '0;
    r.kind  = kind;
    r.code  = code;
    r.reply = data;
    r.count = cnt;
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Take an item only when the result queue has room for two results
  assign it     = q_item;
  assign oq_pop = out_valid && out_ready;
  assign take   = q_valid && (oq_cnt_r <= CNT_W'(DEPTH - 2) + CNT_W'(oq_pop));
  assign q_pop  = take;

  // Carry out the item
  always_comb begin
    busy_nxt          = busy_r;
    req_id_nxt        = req_id_r;
    req_ext_nxt       = req_ext_r;
    req_len_nxt       = req_len_r;
    req_bytes_nxt     = req_bytes_r;
    want_len_nxt      = want_len_r;
    frames_needed_nxt = frames_needed_r;
    frame_idx_nxt     = frame_idx_r;
    tries_left_nxt    = tries_left_r;
    got_len_nxt       = got_len_r;
    accum_nxt         = accum_r;
    comm_err_nxt      = comm_err_r;
    r0                = '0;
    r1                = '0;
    nres              = 2'd0;

    expect_id = req_ext_r ? (req_id_r | EXT_MATCH_BIT) : (req_id_r | STD_MATCH_BIT);
    tries_dec = (tries_left_r != 4'd0) ? tries_left_r - 4'd1 : 4'd0;
    reload    = (tries_cfg == 4'd0) ? 4'd1 : tries_cfg;
    got_sum   = got_len_r + {3'b000, it.dlc};
    idx_inc   = frame_idx_r + 4'd1;
    comm_inc  = (comm_err_r == ERR_COUNT_MAX) ? comm_err_r : comm_err_r + 8'd1;
    accum_new = accum_r
              | ((frame_idx_r == 4'd0) ? it.pack_lo : 64'h0)
              | ((frame_idx_r == 4'd1) ? {it.pack_hi, 56'h0} : 64'h0);

    if (take) begin
      case (it.cmd)
        CMD_START: begin
          busy_nxt = 1'b0;
          if (comm_err_r >= limit_cfg) begin
            r0   = mk_res(KIND_ERR, ERR_COMM_LIMIT, 64'h0, comm_err_r);
            nres = 2'd1;
          end else begin
            req_id_nxt        = it.id;
            req_ext_nxt       = it.ext;
            req_len_nxt       = it.len;
            req_bytes_nxt     = it.bytes;
            want_len_nxt      = it.rlen;
            frames_needed_nxt = it.frames;
            frame_idx_nxt     = 4'd0;
            tries_left_nxt    = reload;
            got_len_nxt       = 7'd0;
            accum_nxt         = 64'h0;
            comm_err_nxt      = 8'd0;
            r0          = mk_res(KIND_TX, ERR_NONE, 64'h0, 8'd0);
            r0.tx_id    = it.id;
            r0.tx_ext   = it.ext;
            r0.tx_len   = it.len;
            r0.tx_bytes = it.bytes;
            // zero reply length finishes at once
            if (it.frames == 4'd0) begin
              r1   = mk_res(KIND_DONE, ERR_NONE, 64'h0, 8'd0);
              nres = 2'd2;
            end else begin
              busy_nxt = 1'b1;
              nres     = 2'd1;
            end
          end
        end
        CMD_BUS_ERR: begin
          comm_err_nxt = comm_inc;
          busy_nxt     = 1'b0;
          r0           = mk_res(KIND_ERR, ERR_BUS, 64'h0, comm_inc);
          nres         = 2'd1;
        end
        CMD_TIMEOUT: begin
          if (busy_r) begin
            // retransmit and spend a try
            r0             = mk_res(KIND_TX, ERR_NONE, 64'h0, comm_err_r);
            r0.tx_id       = req_id_r;
            r0.tx_ext      = req_ext_r;
            r0.tx_len      = req_len_r;
            r0.tx_bytes    = req_bytes_r;
            tries_left_nxt = tries_dec;
            if (tries_dec == 4'd0) begin
              busy_nxt = 1'b0;
              r1       = mk_res(KIND_ERR, ERR_NO_REPLY, 64'h0, comm_err_r);
              nres     = 2'd2;
            end else begin
              nres = 2'd1;
            end
          end
        end
        CMD_RX: begin
          if (busy_r) begin
            if (it.id != expect_id) begin
              tries_left_nxt = tries_dec;
              if (tries_dec == 4'd0) begin
                busy_nxt = 1'b0;
                r0       = mk_res(KIND_ERR, ERR_NO_REPLY, 64'h0, comm_err_r);
                nres     = 2'd1;
              end
            end else if ((it.bytes[7:0] != req_bytes_r[7:0]) && !it.echo_free) begin
              busy_nxt = 1'b0;
              r0       = mk_res(KIND_ERR, ERR_ECHO, 64'h0, comm_err_r);
              nres     = 2'd1;
            end else begin
              got_len_nxt    = got_sum;
              accum_nxt      = accum_new;
              frame_idx_nxt  = idx_inc;
              tries_left_nxt = reload;
              if (idx_inc >= frames_needed_r) begin
                busy_nxt = 1'b0;
                if (got_sum == want_len_r) begin
                  r0 = mk_res(KIND_DONE, ERR_NONE, accum_new, comm_err_r);
                end else begin
                  r0 = mk_res(KIND_ERR, ERR_LENGTH, 64'h0, comm_err_r);
                end
                nres = 2'd1;
              end
            end
          end
        end
        default: ;
      endcase

      // mark the final result of the item
      if (nres == 2'd1) begin
        r0.last = 1'b1;
      end else if (nres == 2'd2) begin
        r1.last = 1'b1;
      end
    end
  end

  // Transaction state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r          <= 1'b0;
      req_id_r        <= '0;
      req_ext_r       <= 1'b0;
      req_len_r       <= '0;
      req_bytes_r     <= '0;
      want_len_r      <= '0;
      frames_needed_r <= '0;
      frame_idx_r     <= '0;
      tries_left_r    <= '0;
      got_len_r       <= '0;
      accum_r         <= '0;
      comm_err_r      <= '0;
    end else begin
      busy_r          <= busy_nxt;
      req_id_r        <= req_id_nxt;
      req_ext_r       <= req_ext_nxt;
      req_len_r       <= req_len_nxt;
      req_bytes_r     <= req_bytes_nxt;
      want_len_r      <= want_len_nxt;
      frames_needed_r <= frames_needed_nxt;
      frame_idx_r     <= frame_idx_nxt;
      tries_left_r    <= tries_left_nxt;
      got_len_r       <= got_len_nxt;
      accum_r         <= accum_nxt;
      comm_err_r      <= comm_err_nxt;
    end
  end

  // Result queue
  assign wp_inc1   = ptr_inc(oq_wp_r);
  assign wp_inc2   = ptr_inc(wp_inc1);
  assign rp_inc    = ptr_inc(oq_rp_r);
  assign out_valid = (oq_cnt_r != '0);
  assign out_res   = oq_mem[oq_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (nres == 2'd1) begin
        oq_wp_r <= wp_inc1;
      end else if (nres == 2'd2) begin
        oq_wp_r <= wp_inc2;
      end
      if (oq_pop) begin
        oq_rp_r <= rp_inc;
      end
      oq_cnt_r <= oq_cnt_r + CNT_W'(nres) - CNT_W'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (nres != 2'd0) begin
      oq_mem[oq_wp_r] <= r0;
    end
    if (nres == 2'd2) begin
      oq_mem[wp_inc1] <= r1;
    end
  end

endmodule

@@ rtl/can_request_reply_engine.sv @@
// ----------------------------------------------------------------------------
// can_request_reply_engine
// CAN request/reply transaction engine: sends a request, collects and packs
// matching reply frames, counts retries and communication errors.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+-----------------------------
//  in_       | input     | in_valid / in_ready    | cmd, frame id/ext/len/bytes,
//            |           |                        | reply_length
//  out_      | output    | out_valid / out_ready  | kind, tx frame, reply_data,
//            |           |                        | error_code/count, last
//  apb       | config    | psel/penable, pready=1 | limit @0x0, tries @0x4
//
//  The sustained rate is one item per cycle while the result queue has room for
//  two results; one result per cycle leaves on the output while out_ready is
//  high. An accepted item is registered in the input queue, then its results
//  in the result queue. Items that cause two results hold two result slots.
//  The back end takes an item only when the four-deep result queue has room
//  for two results; the two-deep input queue absorbs the difference.
//  Reset is synchronous and empties both queues; no clearing pass is needed.
// ----------------------------------------------------------------------------
module can_request_reply_engine import crre_pkg::*; #(
  parameter int IQ_DEPTH = 2,
  parameter int OQ_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [28:0] in_frame_id,
  input  logic        in_frame_extended,
  input  logic [3:0]  in_frame_len,
  input  logic [63:0] in_frame_bytes,
  input  logic [6:0]  in_reply_length,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [28:0] out_tx_id,
  output logic        out_tx_extended,
  output logic [3:0]  out_tx_len,
  output logic [63:0] out_tx_bytes,
  output logic [63:0] out_reply_data,
  output logic [2:0]  out_error_code,
  output logic [7:0]  out_error_count,
  output logic        out_last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] comm_limit_r;
  logic [3:0] tries_r;
  logic       cfg_wr;
  logic       q_valid;
  item_t      q_item;
  logic       q_pop;
  res_t       res;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comm_limit_r <= COMM_LIMIT_RST;
      tries_r      <= TRIES_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_COMM_ERROR_LIMIT) begin
        comm_limit_r <= pwdata[7:0];
      end else begin
        tries_r <= pwdata[3:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_TRIES_PER_FRAME) ? {28'h0, tries_r} : {24'h0, comm_limit_r};

  crre_front #(
    .DEPTH(IQ_DEPTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_frame_id      (in_frame_id),
    .in_frame_extended(in_frame_extended),
    .in_frame_len     (in_frame_len),
    .in_frame_bytes   (in_frame_bytes),
    .in_reply_length  (in_reply_length),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  crre_back #(
    .DEPTH(OQ_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .limit_cfg(comm_limit_r),
    .tries_cfg(tries_r),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (res)
  );

  // Drive the result ports
  assign out_kind        = res.kind;
  assign out_tx_id       = res.tx_id;
  assign out_tx_extended = res.tx_ext;
  assign out_tx_len      = res.tx_len;
  assign out_tx_bytes    = res.tx_bytes;
  assign out_reply_data  = res.reply;
  assign out_error_code  = res.code;
  assign out_error_count = res.count;
  assign out_last        = res.last;

  // Queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Frame fields only travel with a transmit result
  a_tx_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_TX) |->
      (out_tx_id == 29'h0) && (out_tx_bytes == 64'h0) && (out_tx_len == 4'h0))
    else $error("frame fields set on a non-transmit result");

  // Error code only on error results
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_ERR) |-> (out_error_code == ERR_NONE))
    else $error("error code set on a non-error result");

  // Reply data only on completion
  a_reply_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_DONE) |-> (out_reply_data == 64'h0))
    else $error("reply data set on a result other than done");

endmodule
